FILE: rtl/huffman_code_length_builder_defines.svh
// ---------------------------------------------------------------------------
// huffman code length builder assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_LENGTH_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_LENGTH_BUILDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HCLB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HCLB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define HCLB_ASSERT_IMP(lbl, ante, cons, msg)
`define HCLB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/hclb_pkg.sv
// ---------------------------------------------------------------------------
// hclb_pkg
// shared types and constants of the huffman code length builder
// ---------------------------------------------------------------------------
`default_nettype none

package hclb_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int FREQ_BITS   = 24;
  localparam int WORD_BITS   = 29;
  localparam int ADDR_BITS   = 5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_ORDER    = 2'd2;

  localparam logic KIND_LENGTH = 1'b0;
  localparam logic KIND_LEVEL  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_ONE,
    ST_P1_RD,
    ST_P1_SEL1,
    ST_P1_RD2,
    ST_P1_SEL2,
    ST_P1_WR,
    ST_P2_INIT,
    ST_P2_RDX,
    ST_P2_RDP,
    ST_P2_WR,
    ST_P3_INIT,
    ST_P3_RD,
    ST_P3_CMP,
    ST_P3_ASN,
    ST_K_RD,
    ST_K_EMIT,
    ST_T_RD,
    ST_T_CNT,
    ST_T_EMIT
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0] raddr_a;
    logic [ADDR_BITS-1:0] raddr_b;
  } mem_req_t;

  // position 1..32 to memory slot 0..31
  function automatic logic [ADDR_BITS-1:0] slot(input logic [5:0] pos);
    logic [5:0] t;
    t = pos - 6'd1;
    return t[ADDR_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/huffman_code_length_builder.sv
// ---------------------------------------------------------------------------
// huffman_code_length_builder
// in-place minimum-redundancy code lengths plus canonical decode table
// ---------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall    frequency, last
//  out      output     out_valid/out_stall  kind, index, code_length,
//                                           level_count, base, offset,
//                                           lj_limit, error, last_result
//
// a non-last frequency is stored if the work array has room; the last one
// starts a run of pairing, depths, lengths, length transactions and table
// transactions
// in_stall is high for the whole run; reset is synchronous and clears the
// sequencer, counters and output valid; out_stall freezes the sequencer
// only at a state that has a transaction to hand over
`default_nettype none

`include "huffman_code_length_builder_defines.svh"

module huffman_code_length_builder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] frequency,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [5:0]       index,
  output logic [4:0]       code_length,
  output logic [5:0]       level_count,
  output logic [30:0]      base,
  output logic [5:0]       offset,
  output logic [31:0]      lj_limit,
  output logic [1:0]       error,
  output logic             last_result
);

  hclb_pkg::state_t state, state_next;

  // run bookkeeping
  logic [5:0]                     sym_count;
  logic [hclb_pkg::FREQ_BITS-1:0] prev_freq;
  logic [1:0]                     err_flag;
  logic [1:0]                     err_code;
  logic [4:0]                     max_len;
  logic [5:0]                     num_sym;

  // sequencer pointers and accumulators
  logic [5:0]                     r_ptr;
  logic [5:0]                     s_ptr;
  logic [5:0]                     x_ptr;
  logic [hclb_pkg::WORD_BITS-1:0] acc;
  logic [6:0]                     avail;
  logic [5:0]                     used;
  logic [5:0]                     depth;
  logic [5:0]                     pos;
  logic [4:0]                     lvl;
  logic [5:0]                     cnt;
  logic [31:0]                    base_acc;
  logic [5:0]                     off_acc;

  hclb_pkg::mem_req_t             mreq;
  logic [hclb_pkg::WORD_BITS-1:0] rd_a;
  logic [hclb_pkg::WORD_BITS-1:0] rd_b;

  hclb_work_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // input side
  logic       in_acc;
  logic       full;
  logic [1:0] err_ovf;
  logic [1:0] err_fin;
  logic [5:0] cnt_fin;

  assign in_stall = (state != hclb_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (sym_count >= 6'(hclb_pkg::MAX_SYMBOLS));
  assign cnt_fin  = full ? sym_count : sym_count + 6'd1;

  always_comb begin
    err_ovf = (full && err_flag == hclb_pkg::ERR_NONE) ? hclb_pkg::ERR_OVERFLOW : err_flag;
    err_fin = err_ovf;
    if (frequency[hclb_pkg::FREQ_BITS-1:0] > prev_freq && err_ovf == hclb_pkg::ERR_NONE) begin
      err_fin = hclb_pkg::ERR_ORDER;
    end
  end

  // shared compare unit decisions
  logic out_free;
  logic p1_int;
  logic p3_match;
  logic t_match;
  logic [hclb_pkg::WORD_BITS-1:0] p1_pick;

  assign out_free = !out_valid || !out_stall;
  assign p1_int   = (s_ptr == 6'd0) || ((r_ptr > x_ptr) && (rd_a < rd_b));
  assign p1_pick  = p1_int ? rd_a : rd_b;
  assign p3_match = (r_ptr <= num_sym) && (rd_a == hclb_pkg::WORD_BITS'(depth));
  assign t_match  = (pos <= num_sym) && (rd_a == hclb_pkg::WORD_BITS'(lvl));

  // table entry arithmetic
  logic [31:0] base_nx;
  logic [4:0]  lj_sh;
  logic [31:0] lj_val;

  assign base_nx = 32'((base_acc + 32'(cnt)) << 1);
  assign lj_sh   = max_len - lvl - 5'd1;
  assign lj_val  = (lvl == max_len) ? (32'd1 << max_len) : (base_nx << lj_sh);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hclb_pkg::ST_IDLE: begin
        if (in_acc && last) begin
          if (err_fin != hclb_pkg::ERR_NONE) begin
            state_next = hclb_pkg::ST_ERR;
          end else if (cnt_fin == 6'd1) begin
            state_next = hclb_pkg::ST_ONE;
          end else begin
            state_next = hclb_pkg::ST_P1_RD;
          end
        end
      end
      hclb_pkg::ST_ERR:     if (out_free) state_next = hclb_pkg::ST_IDLE;
      hclb_pkg::ST_ONE:     state_next = hclb_pkg::ST_K_RD;
      hclb_pkg::ST_P1_RD:   state_next = hclb_pkg::ST_P1_SEL1;
      hclb_pkg::ST_P1_SEL1: state_next = hclb_pkg::ST_P1_RD2;
      hclb_pkg::ST_P1_RD2:  state_next = hclb_pkg::ST_P1_SEL2;
      hclb_pkg::ST_P1_SEL2: state_next = hclb_pkg::ST_P1_WR;
      hclb_pkg::ST_P1_WR: begin
        state_next = (x_ptr == 6'd2) ? hclb_pkg::ST_P2_INIT : hclb_pkg::ST_P1_RD;
      end
      hclb_pkg::ST_P2_INIT: begin
        state_next = (num_sym >= 6'd3) ? hclb_pkg::ST_P2_RDX : hclb_pkg::ST_P3_INIT;
      end
      hclb_pkg::ST_P2_RDX:  state_next = hclb_pkg::ST_P2_RDP;
      hclb_pkg::ST_P2_RDP:  state_next = hclb_pkg::ST_P2_WR;
      hclb_pkg::ST_P2_WR: begin
        state_next = (x_ptr == num_sym) ? hclb_pkg::ST_P3_INIT : hclb_pkg::ST_P2_RDX;
      end
      hclb_pkg::ST_P3_INIT: state_next = hclb_pkg::ST_P3_RD;
      hclb_pkg::ST_P3_RD:   state_next = hclb_pkg::ST_P3_CMP;
      hclb_pkg::ST_P3_CMP: begin
        state_next = p3_match ? hclb_pkg::ST_P3_RD : hclb_pkg::ST_P3_ASN;
      end
      hclb_pkg::ST_P3_ASN: begin
        if (avail <= {1'b0, used}) begin
          if (used != 6'd0 && depth < 6'd63) begin
            state_next = hclb_pkg::ST_P3_RD;
          end else begin
            state_next = hclb_pkg::ST_K_RD;
          end
        end
      end
      hclb_pkg::ST_K_RD:    state_next = hclb_pkg::ST_K_EMIT;
      hclb_pkg::ST_K_EMIT: begin
        if (out_free) begin
          state_next = (x_ptr == num_sym) ? hclb_pkg::ST_T_RD : hclb_pkg::ST_K_RD;
        end
      end
      hclb_pkg::ST_T_RD:    state_next = hclb_pkg::ST_T_CNT;
      hclb_pkg::ST_T_CNT: begin
        state_next = t_match ? hclb_pkg::ST_T_RD : hclb_pkg::ST_T_EMIT;
      end
      hclb_pkg::ST_T_EMIT: begin
        if (out_free) begin
          state_next = (lvl == max_len) ? hclb_pkg::ST_IDLE : hclb_pkg::ST_T_RD;
        end
      end
      default:              state_next = hclb_pkg::ST_IDLE;
    endcase
  end

  // memory requests and output loads
  logic out_load;

  always_comb begin
    mreq         = '0;
    mreq.raddr_a = hclb_pkg::slot(r_ptr);
    mreq.raddr_b = hclb_pkg::slot(s_ptr);
    out_load     = 1'b0;
    unique case (state)
      hclb_pkg::ST_IDLE: begin
        mreq.we    = in_acc && !full;
        mreq.waddr = sym_count[hclb_pkg::ADDR_BITS-1:0];
        mreq.wdata = hclb_pkg::WORD_BITS'(frequency[hclb_pkg::FREQ_BITS-1:0]);
      end
      hclb_pkg::ST_ERR:  out_load = out_free;
      hclb_pkg::ST_ONE: begin
        mreq.we    = 1'b1;
        mreq.waddr = hclb_pkg::slot(6'd1);
        mreq.wdata = hclb_pkg::WORD_BITS'(1);
      end
      hclb_pkg::ST_P1_SEL1, hclb_pkg::ST_P1_SEL2: begin
        mreq.we    = p1_int;
        mreq.waddr = hclb_pkg::slot(r_ptr);
        mreq.wdata = hclb_pkg::WORD_BITS'(x_ptr);
      end
      hclb_pkg::ST_P1_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = hclb_pkg::slot(x_ptr);
        mreq.wdata = acc;
      end
      hclb_pkg::ST_P2_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = hclb_pkg::slot(6'd2);
        mreq.wdata = '0;
      end
      hclb_pkg::ST_P2_RDX: mreq.raddr_a = hclb_pkg::slot(x_ptr);
      hclb_pkg::ST_P2_RDP: mreq.raddr_a = hclb_pkg::slot(rd_a[5:0]);
      hclb_pkg::ST_P2_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = hclb_pkg::slot(x_ptr);
        mreq.wdata = rd_a + hclb_pkg::WORD_BITS'(1);
      end
      hclb_pkg::ST_P3_ASN: begin
        mreq.we    = (avail > {1'b0, used}) && (x_ptr <= num_sym);
        mreq.waddr = hclb_pkg::slot(x_ptr);
        mreq.wdata = hclb_pkg::WORD_BITS'(depth);
      end
      hclb_pkg::ST_K_RD, hclb_pkg::ST_K_EMIT: begin
        mreq.raddr_a = hclb_pkg::slot(x_ptr);
        out_load     = (state == hclb_pkg::ST_K_EMIT) && out_free;
      end
      hclb_pkg::ST_T_RD:   mreq.raddr_a = hclb_pkg::slot(pos);
      hclb_pkg::ST_T_EMIT: out_load = out_free;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hclb_pkg::ST_IDLE;
      sym_count <= '0;
      prev_freq <= '1;
      err_flag  <= hclb_pkg::ERR_NONE;
      max_len   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        if (last) begin
          // every last transaction starts a fresh run
          sym_count <= '0;
          prev_freq <= '1;
          err_flag  <= hclb_pkg::ERR_NONE;
        end else begin
          sym_count <= cnt_fin;
          prev_freq <= frequency[hclb_pkg::FREQ_BITS-1:0];
          err_flag  <= err_fin;
        end
      end
      if (state == hclb_pkg::ST_ONE) begin
        max_len <= 5'd1;
      end else if (state == hclb_pkg::ST_P3_ASN && avail > {1'b0, used} && x_ptr == num_sym) begin
        // the last symbol carries the longest length
        max_len <= depth[4:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      hclb_pkg::ST_IDLE: begin
        if (in_acc && last) begin
          num_sym  <= cnt_fin;
          err_code <= err_fin;
          r_ptr    <= cnt_fin;
          s_ptr    <= cnt_fin;
          x_ptr    <= (cnt_fin == 6'd1) ? 6'd1 : cnt_fin;
        end
      end
      hclb_pkg::ST_P1_SEL1: begin
        acc <= p1_pick;
        if (p1_int) r_ptr <= r_ptr - 6'd1;
        else        s_ptr <= s_ptr - 6'd1;
      end
      hclb_pkg::ST_P1_SEL2: begin
        acc <= acc + p1_pick;
        if (p1_int) r_ptr <= r_ptr - 6'd1;
        else        s_ptr <= s_ptr - 6'd1;
      end
      hclb_pkg::ST_P1_WR:   if (x_ptr != 6'd2) x_ptr <= x_ptr - 6'd1;
      hclb_pkg::ST_P2_INIT: x_ptr <= 6'd3;
      hclb_pkg::ST_P2_WR:   x_ptr <= x_ptr + 6'd1;
      hclb_pkg::ST_P3_INIT: begin
        avail <= 7'd1;
        used  <= '0;
        depth <= '0;
        r_ptr <= 6'd2;
        x_ptr <= 6'd1;
      end
      hclb_pkg::ST_P3_CMP: begin
        if (p3_match) begin
          used  <= used + 6'd1;
          r_ptr <= r_ptr + 6'd1;
        end
      end
      hclb_pkg::ST_P3_ASN: begin
        if (avail > {1'b0, used}) begin
          x_ptr <= x_ptr + 6'd1;
          avail <= avail - 7'd1;
        end else begin
          avail <= {used, 1'b0};
          depth <= depth + 6'd1;
          used  <= '0;
          // leaf positions run on across depths; rewind only for the length scan
          if (used == 6'd0 || depth >= 6'd63) x_ptr <= 6'd1;
        end
      end
      hclb_pkg::ST_K_EMIT: begin
        if (out_free) begin
          x_ptr    <= x_ptr + 6'd1;
          pos      <= 6'd1;
          lvl      <= 5'd1;
          cnt      <= '0;
          base_acc <= '0;
          off_acc  <= 6'd1;
        end
      end
      hclb_pkg::ST_T_CNT: begin
        if (t_match) begin
          cnt <= cnt + 6'd1;
          pos <= pos + 6'd1;
        end
      end
      hclb_pkg::ST_T_EMIT: begin
        if (out_free) begin
          lvl      <= lvl + 5'd1;
          cnt      <= '0;
          base_acc <= base_nx;
          off_acc  <= off_acc + cnt;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (state)
        hclb_pkg::ST_ERR: begin
          kind        <= hclb_pkg::KIND_LEVEL;
          index       <= '0;
          code_length <= '0;
          level_count <= '0;
          base        <= '0;
          offset      <= '0;
          lj_limit    <= '0;
          error       <= err_code;
          last_result <= 1'b1;
        end
        hclb_pkg::ST_K_EMIT: begin
          kind        <= hclb_pkg::KIND_LENGTH;
          index       <= x_ptr;
          code_length <= rd_a[4:0];
          level_count <= '0;
          base        <= '0;
          offset      <= '0;
          lj_limit    <= '0;
          error       <= hclb_pkg::ERR_NONE;
          last_result <= 1'b0;
        end
        default: begin
          kind        <= hclb_pkg::KIND_LEVEL;
          index       <= {1'b0, lvl};
          code_length <= '0;
          level_count <= cnt;
          base        <= base_acc[30:0];
          offset      <= off_acc;
          lj_limit    <= lj_val;
          error       <= hclb_pkg::ERR_NONE;
          last_result <= (lvl == max_len);
        end
      endcase
    end
  end

  // checks
  `HCLB_ASSERT_IMP(a_busy_count_clear, state != hclb_pkg::ST_IDLE, sym_count == 6'd0, "symbol count not cleared during run")
  `HCLB_ASSERT_IMP(a_leaf_behind_node, state == hclb_pkg::ST_P1_SEL1, s_ptr <= x_ptr, "leaf pointer passed node pointer")
  `HCLB_ASSERT_IMP(a_level_in_range, state == hclb_pkg::ST_T_EMIT, lvl <= max_len, "table level beyond maximum length")
  `HCLB_ASSERT_NXT(a_load_sets_valid, out_load, out_valid, "loaded result not presented")

endmodule

`default_nettype wire

FILE: rtl/hclb_work_mem.sv
// ---------------------------------------------------------------------------
// hclb_work_mem
// work array: one write port, two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none

module hclb_work_mem (
  input  wire logic                          clk,
  input  wire hclb_pkg::mem_req_t            req,
  output logic [hclb_pkg::WORD_BITS-1:0]     rdata_a,
  output logic [hclb_pkg::WORD_BITS-1:0]     rdata_b
);

  logic [hclb_pkg::WORD_BITS-1:0] mem [2**hclb_pkg::ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

`default_nettype wire
